[rtl/assert_macros.svh]
// Assertion macros shared by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

[rtl/life_pkg.sv]
// Shared types, widths and codes of the toroidal life grid block.
package life_pkg;

    localparam int ROWS_DEF = 64;
    localparam int COLS_DEF = 256;

    localparam int OP_W  = 2;
    localparam int ROW_W = 6;
    localparam int COL_W = 8;
    localparam int CNT_W = 4;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

    // B3/S23: born with three neighbors, kept alive with two or three.
    localparam logic [CNT_W-1:0] BIRTH_CNT = 4'd3;
    localparam logic [CNT_W-1:0] KEEP_CNT  = 4'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_FINISH,
        ST_STEP_RD,
        ST_STEP_SHIFT,
        ST_STEP_WR
    } state_t;

    typedef struct packed {
        logic shift;
        logic load_first;
        logic use_first;
        logic we;
        logic wr_step;
        logic wr_clear;
    } ctl_t;

endpackage

[rtl/life_ram.sv]
// Generic one-write, one-read RAM with registered read data.
module life_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

[rtl/life_cell.sv]
// One column cell: holds a three-row window of its column and computes the next state.
module life_cell (
    input  logic              clk,
    input  life_pkg::ctl_t    ctl,
    input  logic              rd_bit,
    input  logic [1:0]        left_sum,
    input  logic [1:0]        right_sum,
    output logic [1:0]        col_sum,
    output logic              next_bit
);

    logic up_reg;
    logic mid_reg;
    logic dn_reg;
    logic first_reg;
    logic [life_pkg::CNT_W-1:0] count;

    // Rows move up the window by one on every shift; the old top row zero is
    // kept aside because it is overwritten before the last row needs it.
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            up_reg  <= mid_reg;
            mid_reg <= dn_reg;
            dn_reg  <= ctl.use_first ? first_reg : rd_bit;
            if (ctl.load_first)
            begin
                first_reg <= rd_bit;
            end
        end
    end

    assign col_sum = {1'b0, up_reg} + {1'b0, mid_reg} + {1'b0, dn_reg};

    assign count = {2'b00, left_sum} + {2'b00, right_sum}
                 + {3'b000, up_reg} + {3'b000, dn_reg};

    assign next_bit = (count == life_pkg::BIRTH_CNT)
                   || ((count == life_pkg::KEEP_CNT) && mid_reg);

endmodule

[rtl/life_ctrl.sv]
// Sequencer: operation decode, row walk of a generation, clearing pass and result register.
module life_ctrl #(
    parameter int ROWS = life_pkg::ROWS_DEF,
    parameter int COLS = life_pkg::COLS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [life_pkg::OP_W-1:0]     op,
    input  logic [life_pkg::ROW_W-1:0]    row,
    input  logic [life_pkg::COL_W-1:0]    col,
    input  logic                          cell_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          cell_out,
    output logic [life_pkg::OP_W-1:0]     op_done,
    input  logic                          rd_bit,
    output life_pkg::ctl_t                ctl,
    output logic [$clog2(ROWS)-1:0]       raddr,
    output logic [$clog2(ROWS)-1:0]       waddr,
    output logic [$clog2(COLS)-1:0]       col_idx,
    output logic                          wbit
);

    localparam int AW   = $clog2(ROWS);
    localparam int RI_W = $clog2(ROWS + 2);
    localparam logic [RI_W-1:0] RI_LAST = RI_W'(ROWS + 1);
    localparam logic [RI_W-1:0] RI_ROWS = RI_W'(ROWS);
    localparam logic [RI_W-1:0] RI_CLR_END = RI_W'(ROWS - 1);

    life_pkg::state_t state_reg, state_next;
    logic [RI_W-1:0]  ri_reg, ri_next;
    logic [RI_W-1:0]  ri_m1;
    logic [RI_W-1:0]  ri_m2;

    logic [life_pkg::OP_W-1:0]  op_reg;
    logic [life_pkg::ROW_W-1:0] row_reg;
    logic [life_pkg::COL_W-1:0] col_reg;
    logic                       val_reg;
    logic                       in_grid_reg;
    logic                       in_grid;
    logic [31:0]                row_wide;
    logic [31:0]                col_wide;
    logic [AW-1:0]              row_idx;

    logic                       out_valid_reg;
    logic                       cell_out_reg;
    logic [life_pkg::OP_W-1:0]  op_done_reg;
    logic                       fin_go;
    logic                       accept;

    assign accept  = in_valid && in_ready;
    assign in_grid = (32'(row) < 32'(ROWS)) && (32'(col) < 32'(COLS));
    assign fin_go  = (state_reg == life_pkg::ST_FINISH) && (!out_valid_reg || out_ready);

    assign row_wide = 32'(row_reg);
    assign col_wide = 32'(col_reg);
    assign row_idx  = row_wide[AW-1:0];
    assign col_idx  = col_wide[$clog2(COLS)-1:0];
    assign wbit     = val_reg;
    assign ri_m1    = ri_reg - RI_W'(1);
    assign ri_m2    = ri_reg - RI_W'(2);

    // Next state and row counter.
    always_comb
    begin
        state_next = state_reg;
        ri_next    = ri_reg;
        case (state_reg)
            life_pkg::ST_CLEAR:
            begin
                ri_next = ri_reg + RI_W'(1);
                if (ri_reg == RI_CLR_END)
                begin
                    state_next = life_pkg::ST_IDLE;
                    ri_next    = '0;
                end
            end
            life_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    ri_next = '0;
                    case (op)
                        life_pkg::OP_WRITE, life_pkg::OP_READ:
                            state_next = life_pkg::ST_ACCESS;
                        life_pkg::OP_STEP:
                            state_next = life_pkg::ST_STEP_RD;
                        default:
                            state_next = life_pkg::ST_FINISH;
                    endcase
                end
            end
            life_pkg::ST_ACCESS:
                state_next = life_pkg::ST_FINISH;
            life_pkg::ST_FINISH:
            begin
                if (fin_go)
                begin
                    state_next = life_pkg::ST_IDLE;
                end
            end
            life_pkg::ST_STEP_RD:
                state_next = life_pkg::ST_STEP_SHIFT;
            life_pkg::ST_STEP_SHIFT:
            begin
                // The window is full once three rows have gone in.
                if (ri_reg >= RI_W'(2))
                begin
                    state_next = life_pkg::ST_STEP_WR;
                end
                else
                begin
                    ri_next    = ri_reg + RI_W'(1);
                    state_next = life_pkg::ST_STEP_RD;
                end
            end
            life_pkg::ST_STEP_WR:
            begin
                ri_next = ri_reg + RI_W'(1);
                if (ri_reg == RI_LAST)
                begin
                    state_next = life_pkg::ST_FINISH;
                end
                else if (ri_reg == RI_ROWS)
                begin
                    // The last window closes with the saved row zero, no read needed.
                    state_next = life_pkg::ST_STEP_SHIFT;
                end
                else
                begin
                    state_next = life_pkg::ST_STEP_RD;
                end
            end
            default:
                state_next = life_pkg::ST_CLEAR;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_ready       = (state_reg == life_pkg::ST_IDLE);
        ctl.shift      = (state_reg == life_pkg::ST_STEP_SHIFT);
        ctl.load_first = (state_reg == life_pkg::ST_STEP_SHIFT) && (ri_reg == RI_W'(1));
        ctl.use_first  = (ri_reg == RI_LAST);
        ctl.wr_step    = (state_reg == life_pkg::ST_STEP_WR);
        ctl.wr_clear   = (state_reg == life_pkg::ST_CLEAR);
        ctl.we         = ctl.wr_step || ctl.wr_clear
                      || (fin_go && (op_reg == life_pkg::OP_WRITE) && in_grid_reg);
        raddr          = row_idx;
        waddr          = row_idx;
        case (state_reg)
            life_pkg::ST_CLEAR:
                waddr = ri_reg[AW-1:0];
            life_pkg::ST_STEP_RD:
                raddr = (ri_reg == '0) ? AW'(ROWS - 1) : ri_m1[AW-1:0];
            life_pkg::ST_STEP_WR:
                waddr = ri_m2[AW-1:0];
            default:
            begin
                raddr = row_idx;
                waddr = row_idx;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= life_pkg::ST_CLEAR;
            ri_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ri_reg    <= ri_next;
            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= op;
            row_reg     <= row;
            col_reg     <= col;
            val_reg     <= cell_in;
            in_grid_reg <= in_grid;
        end
        if (fin_go)
        begin
            cell_out_reg <= (op_reg == life_pkg::OP_READ) && in_grid_reg && rd_bit;
            op_done_reg  <= op_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign cell_out  = cell_out_reg;
    assign op_done   = op_done_reg;

endmodule

[rtl/life_automaton_torus_step.sv]
// Write/read one cell: the input beat is taken in ST_IDLE, the row is read in ST_ACCESS, and
// ST_FINISH fills the result register. A generation step passes the grid rows in turn through
// the column cells over one RAM port. One item is in flight at a time, so no new input beat is
// taken until the result register is filled; a finished result waits in the output register.
// After reset a clearing pass writes all ROWS rows dead with in_ready low.
// Reset is asynchronous and active low; it clears control state only.
module life_automaton_torus_step #(
    parameter int ROWS = life_pkg::ROWS_DEF,
    parameter int COLS = life_pkg::COLS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [life_pkg::OP_W-1:0]     op,
    input  logic [life_pkg::ROW_W-1:0]    row,
    input  logic [life_pkg::COL_W-1:0]    col,
    input  logic                          cell_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          cell_out,
    output logic [life_pkg::OP_W-1:0]     op_done
);

    life_pkg::ctl_t            ctl;
    logic [$clog2(ROWS)-1:0]   raddr;
    logic [$clog2(ROWS)-1:0]   waddr;
    logic [$clog2(COLS)-1:0]   col_idx;
    logic                      wbit;
    logic                      rd_bit;
    logic [COLS-1:0]           ram_rdata;
    logic [COLS-1:0]           ram_wdata;
    logic [COLS-1:0]           rmw_word;
    logic [COLS-1:0]           next_row;
    logic [1:0]                col_sum [COLS];

    life_ctrl #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .row       (row),
        .col       (col),
        .cell_in   (cell_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cell_out  (cell_out),
        .op_done   (op_done),
        .rd_bit    (rd_bit),
        .ctl       (ctl),
        .raddr     (raddr),
        .waddr     (waddr),
        .col_idx   (col_idx),
        .wbit      (wbit)
    );

    life_ram #(
        .WIDTH (COLS),
        .DEPTH (ROWS)
    ) u_grid (
        .clk   (clk),
        .we    (ctl.we),
        .waddr (waddr),
        .wdata (ram_wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // Single-cell writes modify the row just read and put it back.
    always_comb
    begin
        rmw_word          = ram_rdata;
        rmw_word[col_idx] = wbit;
    end

    assign rd_bit    = ram_rdata[col_idx];
    assign ram_wdata = ctl.wr_clear ? '0 : (ctl.wr_step ? next_row : rmw_word);

    // The chain closes on itself, so the first and last columns are neighbors.
    for (genvar c = 0; c < COLS; c++)
    begin : g_cell
        life_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .rd_bit    (ram_rdata[c]),
            .left_sum  (col_sum[(c + COLS - 1) % COLS]),
            .right_sum (col_sum[(c + 1) % COLS]),
            .col_sum   (col_sum[c]),
            .next_bit  (next_row[c])
        );
    end

endmodule

[rtl/life_chk.sv]
// Port-level checker for the life grid block, bound to the top level.
`include "assert_macros.svh"

module life_chk (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [life_pkg::OP_W-1:0]     op,
    input  logic [life_pkg::ROW_W-1:0]    row,
    input  logic [life_pkg::COL_W-1:0]    col,
    input  logic                          cell_in,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          cell_out,
    input  logic [life_pkg::OP_W-1:0]     op_done
);

    // A stalled result beat holds its payload.
    `ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(op_done) && $stable(cell_out))

    // Only a read returns a live cell.
    `ASSERT_RST(a_cell_only_read, clk, rst_n, out_valid && (op_done != life_pkg::OP_READ) |-> !cell_out)

    // The clearing pass keeps the input closed right after reset.
    `ASSERT_ALWAYS(a_clear_closed, clk, !rst_n |=> !in_ready)

    // One item at a time: an accepted beat closes the input.
    `ASSERT_RST(a_one_in_flight, clk, rst_n, in_valid && in_ready |=> !in_ready)

    // A result appears only while an item was being worked on.
    `ASSERT_RST(a_no_spurious, clk, rst_n, $rose(out_valid) |-> !$past(in_ready))

endmodule

bind life_automaton_torus_step life_chk u_chk (.*);
